FILE: hdl/kdb_pkg.sv
`default_nettype none
package kdb_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned CW = 31;

  localparam logic [CW-1:0] ACCEL_RESET = 31'd131072;
  localparam logic [CW-1:0] DECEL_RESET = 31'd262144;
  localparam logic [CW-1:0] SPEED_RESET = 31'd1310720;

  localparam logic [QW-1:0] Q_HALF = 32'h0000_8000;

  typedef enum logic [1:0] {
    MODE_QUERY   = 2'd0,
    MODE_UPDATE  = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_MAX_ACCEL = 2'd0,
    REG_MAX_DECEL = 2'd1,
    REG_MAX_SPEED = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_WAIT = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // Saturate a signed 34-bit value to 32 bits.
  function automatic logic signed [QW-1:0] sat34(input logic signed [QW+1:0] x);
    logic signed [QW+1:0] hi;
    logic signed [QW+1:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (x > hi) sat34 = 32'sh7FFF_FFFF;
    else if (x < lo) sat34 = 32'sh8000_0000;
    else sat34 = x[QW-1:0];
  endfunction

  function automatic logic signed [QW-1:0] qadd(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    qadd = sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [QW-1:0] qsub(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    qsub = sat34(34'(a) - 34'(b));
  endfunction

endpackage
`default_nettype wire

FILE: hdl/kdb_muldiv.sv
`default_nettype none
// Shared sign-magnitude multiplier and divider. A multiply is a 32x32
// product followed by a registered shift and saturate; a divide is a
// restoring divider that retires one quotient bit per cycle.
module kdb_muldiv (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire kdb_pkg::op_t              op,
  input  wire logic signed [31:0]        a,
  input  wire logic signed [31:0]        b,
  output logic                           done,
  output logic signed [31:0]             result
);

  logic        busy;
  logic        neg;
  logic [47:0] quo;
  logic [31:0] dvs;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        is_div;
  logic [63:0] prod;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [32:0] trial;
  logic [47:0] mag_out;

  assign mag_a = a[31] ? 32'(-a) : 32'(a);
  assign mag_b = b[31] ? 32'(-b) : 32'(b);
  assign trial = {rem[31:0], quo[47]} - {1'b0, dvs};

  always_comb begin
    mag_out = is_div ? quo : prod[63:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        neg    <= a[31] ^ b[31];
        is_div <= (op == kdb_pkg::OP_DIV);
        if (op == kdb_pkg::OP_DIV) begin
          quo <= {mag_a, 16'd0};
          dvs <= (mag_b == 32'd0) ? 32'd1 : mag_b;
          rem <= 33'd0;
          cnt <= 6'd48;
        end else begin
          prod <= mag_a * mag_b;
          cnt  <= 6'd0;
        end
      end else if (busy) begin
        if (cnt != 6'd0) begin
          if (!trial[32]) begin
            rem <= {1'b0, trial[31:0]};
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= {rem[31:0], quo[47]};
            quo <= {quo[46:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) result <= (mag_out >= 48'h8000_0000) ? 32'sh8000_0000 : -$signed(mag_out[31:0]);
          else result <= (mag_out > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag_out[31:0]);
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kinematic_distance_bounds.sv
`default_nettype none
// Reachable distance bounds under constant acceleration limits, all in Q16.16.
// One item is worked at a time through a single shared multiply/divide unit
// driven by a microcode sequencer: query and update each run two quotient
// computations (stop time and ramp time) and eight or nine products, with
// steps to take the item, close it out and present the result; restart
// only takes the item and presents the result, without using the unit.
// s_axis_tready is low while an item is in work; the result waits in an
// output register and the block takes no new item until it is taken.
module kinematic_distance_bounds (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // fields from bit 0: mode[1:0], time_req[32:2], lower_position[64:33],
  // upper_position[96:65], start_speed[127:97]
  input  wire logic [127:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // fields from bit 0: lower_bound[31:0], upper_bound[63:32]
  output logic [63:0]      m_axis_tdata
);

  logic [30:0] max_accel, max_decel, max_speed;
  logic signed [31:0] lat, lav, lap, uat, uav, uap;

  kdb_pkg::state_t state, state_next;
  logic [4:0]  step;
  logic [1:0]  mode;
  logic signed [31:0] t, lpos, upos;
  logic signed [31:0] acc, dcl, vmx;
  // scratch registers
  logic signed [31:0] stop, ldt, reach, udt, r0, r1, lo, hi;

  logic               mstart, mdone;
  kdb_pkg::op_t       mop;
  logic signed [31:0] ma, mb, mres;

  kdb_muldiv u_md (.clk, .rst, .start(mstart), .op(mop), .a(ma), .b(mb),
                   .done(mdone), .result(mres));

  assign acc = {1'b0, max_accel};
  assign dcl = {1'b0, max_decel};
  assign vmx = {1'b0, max_speed};

  assign cfg_ready     = (state == kdb_pkg::ST_IDLE);
  assign s_axis_tready = (state == kdb_pkg::ST_IDLE) && !cfg_valid;
  assign m_axis_tvalid = (state == kdb_pkg::ST_OUT);
  assign m_axis_tdata  = {hi, lo};

  // Microcode: each step issues one unit operation; its result is captured
  // when the unit is done (ldt/udt/adds are folded into operands or capture).
  localparam logic [4:0] LAST = 5'd14;

  always_comb begin
    mop = kdb_pkg::OP_MUL;
    ma  = '0;
    mb  = '0;
    case (step)
      5'd0:  begin mop = kdb_pkg::OP_DIV; ma = lav; mb = dcl; end
      5'd1:  begin ma = dcl; mb = ldt; end
      5'd2:  begin ma = kdb_pkg::qadd(kdb_pkg::qsub(lav, r0), lav); mb = ldt; end
      5'd3:  begin ma = r0; mb = kdb_pkg::Q_HALF; end
      5'd4:  begin ma = lav; mb = stop; end
      5'd5:  begin ma = r0; mb = kdb_pkg::Q_HALF; end
      5'd6:  begin mop = kdb_pkg::OP_DIV; ma = kdb_pkg::qsub(vmx, uav); mb = acc; end
      5'd7:  begin ma = acc; mb = udt; end
      5'd8:  begin ma = kdb_pkg::qadd(kdb_pkg::qadd(uav, r1), uav); mb = udt; end
      5'd9:  begin ma = r0; mb = kdb_pkg::Q_HALF; end
      5'd10: begin ma = kdb_pkg::qadd(uav, vmx); mb = reach; end
      5'd11: begin ma = r0; mb = kdb_pkg::Q_HALF; end
      5'd12: begin ma = kdb_pkg::qsub(udt, reach); mb = vmx; end
      5'd13: begin ma = dcl; mb = ldt; end
      5'd14: begin ma = acc; mb = udt; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      kdb_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tready) state_next = kdb_pkg::ST_RUN;
      kdb_pkg::ST_RUN:
        if (mode == kdb_pkg::MODE_RESTART || step > LAST) state_next = kdb_pkg::ST_OUT;
        else state_next = kdb_pkg::ST_WAIT;
      kdb_pkg::ST_WAIT:
        if (mdone) state_next = kdb_pkg::ST_RUN;
      kdb_pkg::ST_OUT:
        if (m_axis_tready) state_next = kdb_pkg::ST_IDLE;
      default: state_next = kdb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mstart = (state == kdb_pkg::ST_RUN) && (mode != kdb_pkg::MODE_RESTART) && (step <= LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kdb_pkg::ST_IDLE;
      max_accel <= kdb_pkg::ACCEL_RESET;
      max_decel <= kdb_pkg::DECEL_RESET;
      max_speed <= kdb_pkg::SPEED_RESET;
      lat <= '0; lav <= '0; lap <= '0; uat <= '0; uav <= '0; uap <= '0;
      step <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kdb_pkg::REG_MAX_ACCEL: max_accel <= cfg_data;
          kdb_pkg::REG_MAX_DECEL: max_decel <= cfg_data;
          kdb_pkg::REG_MAX_SPEED: max_speed <= cfg_data;
          default: ;
        endcase
      end
      if (state == kdb_pkg::ST_IDLE && s_axis_tvalid && s_axis_tready) begin
        mode <= s_axis_tdata[1:0];
        t    <= {1'b0, s_axis_tdata[32:2]};
        lpos <= s_axis_tdata[64:33];
        upos <= s_axis_tdata[96:65];
        step <= '0;
        if (s_axis_tdata[1:0] == kdb_pkg::MODE_RESTART) begin
          lat <= '0; lap <= '0; uat <= '0; uap <= '0;
          lav <= {1'b0, s_axis_tdata[127:97]};
          uav <= {1'b0, s_axis_tdata[127:97]};
          lo <= '0;
          hi <= '0;
        end
      end
      if (state == kdb_pkg::ST_RUN && step == LAST + 5'd1 && mode == kdb_pkg::MODE_UPDATE) begin
        // Anchor moves compare against the bounds computed in this item's steps.
        if (lo < lpos) begin
          lav <= (r0 < 0) ? 32'sd0 : r0;
          lat <= t;
          lap <= lpos;
        end
        if (hi > upos) begin
          uav <= (r1 > vmx) ? vmx : r1;
          uat <= t;
          uap <= upos;
        end
        step <= step + 5'd1;
      end
      if (state == kdb_pkg::ST_WAIT && mdone) begin
        case (step)
          5'd0: begin stop <= mres; ldt <= kdb_pkg::qsub(t, lat); end
          5'd1: begin
            r0 <= mres;
            if (!(ldt < stop)) step <= 5'd4;
          end
          5'd2: r0 <= mres;
          5'd3: begin lo <= kdb_pkg::qadd(lap, mres); step <= 5'd6; end
          5'd4: r0 <= mres;
          5'd5: lo <= kdb_pkg::qadd(lap, mres);
          5'd6: begin reach <= mres; udt <= kdb_pkg::qsub(t, uat); end
          5'd7: begin
            r1 <= mres;
            if (!(udt < reach)) step <= 5'd10;
          end
          5'd8: r0 <= mres;
          5'd9: begin hi <= kdb_pkg::qadd(uap, mres); step <= 5'd13; end
          5'd10: r0 <= mres;
          5'd11: r1 <= mres;
          5'd12: hi <= kdb_pkg::qadd(kdb_pkg::qadd(uap, r1), mres);
          5'd13: begin
            // Lower speed for update: v0 - dec*dt, kept in r0.
            r0 <= kdb_pkg::qsub(lav, mres);
          end
          5'd14: r1 <= kdb_pkg::qadd(uav, mres);
          default: ;
        endcase
        if (!((step == 5'd1 && !(ldt < stop)) || step == 5'd3
              || (step == 5'd7 && !(udt < reach)) || step == 5'd9))
          step <= step + 5'd1;
      end
    end
  end

endmodule
`default_nettype wire
